// ===== rtl/ptr_pkg.sv =====
package ptr_pkg;

    localparam int PAGES       = 64;
    localparam int FRAMES      = 16;
    localparam int OFFSET_BITS = 12;
    localparam int PAGE_W      = $clog2(PAGES);
    localparam int FRAME_W     = $clog2(FRAMES);
    localparam int TIME_W      = 64;
    localparam int ADDR_W      = 32;
    localparam int PHYS_W      = 16;
    localparam int NPAGE_W     = PAGE_W + 1;
    localparam int NFRAME_W    = FRAME_W + 1;
    localparam int STEP_W      = PAGE_W + 2;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    localparam logic [1:0] POL_LRU   = 2'd1;
    localparam logic [1:0] POL_CLOCK = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_PAGES  = 2'd1;
    localparam logic [1:0] CFG_FRAMES = 2'd2;

    localparam logic [2:0] STAT_HIT     = 3'd0;
    localparam logic [2:0] STAT_FAULT   = 3'd1;
    localparam logic [2:0] STAT_EVICT   = 3'd2;
    localparam logic [2:0] STAT_INVALID = 3'd3;
    localparam logic [2:0] STAT_FLUSHED = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_QREAD,
        ST_LRU_RD,
        ST_LRU_CK,
        ST_CLK_RD,
        ST_CLK_CK,
        ST_VREAD,
        ST_EVICT
    } state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               dirty;
        logic               referenced;
        logic [TIME_W-1:0]  last_use;
    } entry_t;

endpackage

// ===== rtl/ptr_ram.sv =====
module ptr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/page_translate_replace_unit.sv =====
// Channel   Direction  Handshake              Contents
// req       in         req_valid / req_stall  req_type, virt_addr
// res       out        res_valid / res_stall  status, phys_addr, frame_used, evicted_*
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Flush, invalid pages and unused request codes finish in the accepting cycle.
// A hit or a fault into a free frame takes a page table read and then a write-back.
// An eviction adds a victim read and the eviction; before them LRU reads and checks every
// configured page, and clock reads and checks one page per step for at most two passes.
// Reset clears all control state at once; the page table RAM needs no clearing pass.
// A pending result stalls further requests until it is taken.
module page_translate_replace_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      req_type,
    input  logic [ptr_pkg::ADDR_W-1:0]      virt_addr,
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic [2:0]                      status,
    output logic [ptr_pkg::PHYS_W-1:0]      phys_addr,
    output logic [ptr_pkg::FRAME_W-1:0]     frame_used,
    output logic [ptr_pkg::PAGE_W-1:0]      evicted_page,
    output logic                            evicted_dirty,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [6:0]                      cfg_data
);
    import ptr_pkg::*;

    state_t                state_reg, state_next;
    logic [1:0]            policy_reg;
    logic [6:0]            pages_reg;
    logic [4:0]            frames_reg;
    logic [PAGES-1:0]      valid_reg, valid_next;
    logic [FRAMES-1:0]     taken_reg, taken_next;
    logic [FRAME_W-1:0]    qhead_reg, qhead_next;
    logic [NFRAME_W-1:0]   qcount_reg, qcount_next;
    logic [PAGE_W-1:0]     clk_ptr_reg, clk_ptr_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic                  write_reg, write_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [PAGE_W-1:0]     vict_reg, vict_next;
    logic [NPAGE_W-1:0]    scan_reg, scan_next;
    logic [STEP_W-1:0]     steps_reg, steps_next;
    logic [TIME_W-1:0]     best_reg, best_next;
    logic                  res_valid_reg, res_valid_next;
    logic [2:0]            status_reg, status_next;
    logic [PHYS_W-1:0]     phys_reg, phys_next;
    logic [FRAME_W-1:0]    frame_reg, frame_next;
    logic [PAGE_W-1:0]     evp_reg, evp_next;
    logic                  evd_reg, evd_next;

    logic [NPAGE_W-1:0]    np;
    logic [NFRAME_W-1:0]   nf;
    logic [NFRAME_W-1:0]   nf_lim;
    logic                  accept;
    logic                  is_fifo;
    logic                  in_range;
    logic [PAGE_W-1:0]     page_in;
    logic                  hit;
    logic [FRAME_W:0]      lk_free;
    logic [FRAME_W:0]      ev_free;
    logic                  ev_hit;
    logic [FRAMES-1:0]     taken_after;
    logic [PAGE_W-1:0]     first_v;
    logic [NPAGE_W-1:0]    clk_inc;
    logic                  clk_stop;

    logic                  ent_we;
    logic [PAGE_W-1:0]     ent_wa;
    entry_t                ent_wd;
    logic [PAGE_W-1:0]     ent_ra;
    entry_t                ent_rd;
    logic                  q_we;
    logic [FRAME_W-1:0]    q_wa;
    logic [PAGE_W-1:0]     q_rd;

    function automatic logic [FRAME_W:0] find_free(input logic [FRAMES-1:0] taken,
                                                   input logic [NFRAME_W-1:0] lim);
        logic [FRAME_W:0] r;
        r = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!taken[i] && (NFRAME_W'(i) < lim))
            begin
                r = {1'b1, FRAME_W'(i)};
            end
        end
        return r;
    endfunction

    ptr_ram #(.WIDTH($bits(entry_t)), .DEPTH(PAGES)) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_wa),
        .wr_data (ent_wd),
        .rd_addr (ent_ra),
        .rd_data (ent_rd)
    );

    ptr_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_queue_ram (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (q_wa),
        .wr_data (page_reg),
        .rd_addr (qhead_reg),
        .rd_data (q_rd)
    );

    always_comb
    begin
        if (pages_reg == '0)
        begin
            np = NPAGE_W'(1);
        end
        else if (pages_reg > 7'(PAGES))
        begin
            np = NPAGE_W'(PAGES);
        end
        else
        begin
            np = NPAGE_W'(pages_reg);
        end
        nf_lim = (np > NPAGE_W'(FRAMES)) ? NFRAME_W'(FRAMES) : NFRAME_W'(np);
        if (frames_reg == '0)
        begin
            nf = NFRAME_W'(1);
        end
        else if (NFRAME_W'(frames_reg) > nf_lim)
        begin
            nf = nf_lim;
        end
        else
        begin
            nf = NFRAME_W'(frames_reg);
        end
    end

    always_comb
    begin
        first_v = '0;
        for (int i = PAGES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (NPAGE_W'(i) < np))
            begin
                first_v = PAGE_W'(i);
            end
        end
    end

    assign cfg_ready   = 1'b1;
    assign req_stall   = (state_reg != ST_IDLE) || (res_valid_reg && res_stall);
    assign accept      = req_valid && !req_stall;
    assign is_fifo     = (policy_reg != POL_LRU) && (policy_reg != POL_CLOCK);
    assign page_in     = virt_addr[OFFSET_BITS +: PAGE_W];
    assign in_range    = virt_addr[ADDR_W-1:OFFSET_BITS] < (ADDR_W - OFFSET_BITS)'(np);
    assign hit         = valid_reg[page_reg];
    assign lk_free     = find_free(taken_reg, nf);
    assign ev_hit      = valid_reg[vict_reg];
    assign taken_after = ev_hit ? (taken_reg & ~(FRAMES'(1) << ent_rd.frame)) : taken_reg;
    assign ev_free     = find_free(taken_after, nf);
    assign clk_inc     = NPAGE_W'(clk_ptr_reg) + NPAGE_W'(1);
    assign clk_stop    = (valid_reg[clk_ptr_reg] && !ent_rd.referenced)
                         || ((steps_reg + STEP_W'(1)) == {np, 1'b0});

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   ent_ra = page_in;
            ST_QREAD:  ent_ra = q_rd;
            ST_LRU_RD: ent_ra = scan_reg[PAGE_W-1:0];
            ST_CLK_RD: ent_ra = clk_ptr_reg;
            ST_VREAD:  ent_ra = vict_reg;
            default:   ent_ra = page_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_READ || req_type == REQ_WRITE) && in_range)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (hit || lk_free[FRAME_W])
                begin
                    state_next = ST_IDLE;
                end
                else if (policy_reg == POL_LRU)
                begin
                    state_next = ST_LRU_RD;
                end
                else if (policy_reg == POL_CLOCK)
                begin
                    state_next = ST_CLK_RD;
                end
                else if (qcount_reg == '0)
                begin
                    state_next = ST_VREAD;
                end
                else
                begin
                    state_next = ST_QREAD;
                end
            end
            ST_QREAD:  state_next = ST_EVICT;
            ST_VREAD:  state_next = ST_EVICT;
            ST_LRU_RD: state_next = ST_LRU_CK;
            ST_LRU_CK: state_next = ((scan_reg + NPAGE_W'(1)) == np) ? ST_VREAD : ST_LRU_RD;
            ST_CLK_RD: state_next = ST_CLK_CK;
            ST_CLK_CK: state_next = clk_stop ? ST_VREAD : ST_CLK_RD;
            ST_EVICT:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        valid_next     = valid_reg;
        taken_next     = taken_reg;
        qhead_next     = qhead_reg;
        qcount_next    = qcount_reg;
        clk_ptr_next   = clk_ptr_reg;
        time_next      = time_reg;
        write_next     = write_reg;
        page_next      = page_reg;
        offset_next    = offset_reg;
        vict_next      = vict_reg;
        scan_next      = scan_reg;
        steps_next     = steps_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        phys_next      = phys_reg;
        frame_next     = frame_reg;
        evp_next       = evp_reg;
        evd_next       = evd_reg;
        res_valid_next = res_valid_reg && res_stall;
        ent_we         = 1'b0;
        ent_wa         = page_reg;
        ent_wd         = ent_rd;
        q_we           = 1'b0;
        q_wa           = qhead_reg + qcount_reg[FRAME_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    write_next  = (req_type == REQ_WRITE);
                    page_next   = page_in;
                    offset_next = virt_addr[OFFSET_BITS-1:0];
                    status_next = STAT_INVALID;
                    phys_next   = '0;
                    frame_next  = '0;
                    evp_next    = '0;
                    evd_next    = 1'b0;
                    if (req_type == REQ_FLUSH)
                    begin
                        valid_next     = '0;
                        taken_next     = '0;
                        qhead_next     = '0;
                        qcount_next    = '0;
                        clk_ptr_next   = '0;
                        status_next    = STAT_FLUSHED;
                        res_valid_next = 1'b1;
                    end
                    else if (req_type == REQ_READ || req_type == REQ_WRITE)
                    begin
                        time_next = time_reg + TIME_W'(1);
                        if (!in_range)
                        begin
                            res_valid_next = 1'b1;
                        end
                    end
                end
            end
            ST_LOOKUP:
            begin
                if (hit)
                begin
                    ent_we              = 1'b1;
                    ent_wd.dirty        = ent_rd.dirty | write_reg;
                    ent_wd.referenced   = 1'b1;
                    ent_wd.last_use     = time_reg;
                    status_next         = STAT_HIT;
                    phys_next           = PHYS_W'({ent_rd.frame, offset_reg});
                    frame_next          = ent_rd.frame;
                    res_valid_next      = 1'b1;
                end
                else if (lk_free[FRAME_W])
                begin
                    ent_we              = 1'b1;
                    ent_wd.frame        = lk_free[FRAME_W-1:0];
                    ent_wd.dirty        = write_reg;
                    ent_wd.referenced   = 1'b1;
                    ent_wd.last_use     = time_reg;
                    valid_next[page_reg] = 1'b1;
                    taken_next[lk_free[FRAME_W-1:0]] = 1'b1;
                    if (is_fifo && qcount_reg < NFRAME_W'(FRAMES))
                    begin
                        q_we        = 1'b1;
                        qcount_next = qcount_reg + NFRAME_W'(1);
                    end
                    status_next    = STAT_FAULT;
                    phys_next      = PHYS_W'({lk_free[FRAME_W-1:0], offset_reg});
                    frame_next     = lk_free[FRAME_W-1:0];
                    res_valid_next = 1'b1;
                end
                else if (policy_reg == POL_LRU)
                begin
                    scan_next = '0;
                    best_next = '1;
                    vict_next = '0;
                end
                else if (policy_reg == POL_CLOCK)
                begin
                    steps_next = '0;
                    if (NPAGE_W'(clk_ptr_reg) >= np)
                    begin
                        clk_ptr_next = '0;
                    end
                end
                else if (qcount_reg == '0)
                begin
                    vict_next = first_v;
                end
                else
                begin
                    qhead_next  = qhead_reg + FRAME_W'(1);
                    qcount_next = qcount_reg - NFRAME_W'(1);
                end
            end
            ST_QREAD:
            begin
                vict_next = q_rd;
            end
            ST_LRU_CK:
            begin
                if (valid_reg[scan_reg[PAGE_W-1:0]] && ent_rd.last_use < best_reg)
                begin
                    best_next = ent_rd.last_use;
                    vict_next = scan_reg[PAGE_W-1:0];
                end
                scan_next = scan_reg + NPAGE_W'(1);
            end
            ST_CLK_CK:
            begin
                clk_ptr_next = (clk_inc == np) ? '0 : clk_inc[PAGE_W-1:0];
                steps_next   = steps_reg + STEP_W'(1);
                if (valid_reg[clk_ptr_reg] && !ent_rd.referenced)
                begin
                    vict_next = clk_ptr_reg;
                end
                else
                begin
                    if (valid_reg[clk_ptr_reg])
                    begin
                        ent_we            = 1'b1;
                        ent_wa            = clk_ptr_reg;
                        ent_wd.referenced = 1'b0;
                    end
                    vict_next = first_v;
                end
            end
            ST_EVICT:
            begin
                status_next = STAT_FAULT;
                evp_next    = '0;
                evd_next    = 1'b0;
                taken_next  = taken_after;
                if (ev_hit)
                begin
                    evp_next             = vict_reg;
                    evd_next             = ent_rd.dirty;
                    valid_next[vict_reg] = 1'b0;
                    status_next          = STAT_EVICT;
                end
                res_valid_next = 1'b1;
                if (ev_free[FRAME_W])
                begin
                    ent_we              = 1'b1;
                    ent_wd.frame        = ev_free[FRAME_W-1:0];
                    ent_wd.dirty        = write_reg;
                    ent_wd.referenced   = 1'b1;
                    ent_wd.last_use     = time_reg;
                    valid_next[page_reg] = 1'b1;
                    taken_next[ev_free[FRAME_W-1:0]] = 1'b1;
                    if (is_fifo && qcount_reg < NFRAME_W'(FRAMES))
                    begin
                        q_we        = 1'b1;
                        qcount_next = qcount_reg + NFRAME_W'(1);
                    end
                    phys_next  = PHYS_W'({ev_free[FRAME_W-1:0], offset_reg});
                    frame_next = ev_free[FRAME_W-1:0];
                end
                else
                begin
                    status_next = STAT_INVALID;
                    phys_next   = '0;
                    frame_next  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            policy_reg    <= '0;
            pages_reg     <= 7'(PAGES);
            frames_reg    <= 5'(FRAMES);
            valid_reg     <= '0;
            taken_reg     <= '0;
            qhead_reg     <= '0;
            qcount_reg    <= '0;
            clk_ptr_reg   <= '0;
            time_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            taken_reg     <= taken_next;
            qhead_reg     <= qhead_next;
            qcount_reg    <= qcount_next;
            clk_ptr_reg   <= clk_ptr_next;
            time_reg      <= time_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_POLICY)
                begin
                    policy_reg <= cfg_data[1:0];
                end
                else if (cfg_index == CFG_PAGES)
                begin
                    pages_reg <= cfg_data;
                end
                else if (cfg_index == CFG_FRAMES)
                begin
                    frames_reg <= cfg_data[4:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        write_reg  <= write_next;
        page_reg   <= page_next;
        offset_reg <= offset_next;
        vict_reg   <= vict_next;
        scan_reg   <= scan_next;
        steps_reg  <= steps_next;
        best_reg   <= best_next;
        status_reg <= status_next;
        phys_reg   <= phys_next;
        frame_reg  <= frame_next;
        evp_reg    <= evp_next;
        evd_reg    <= evd_next;
    end

    assign res_valid     = res_valid_reg;
    assign status        = status_reg;
    assign phys_addr     = phys_reg;
    assign frame_used    = frame_reg;
    assign evicted_page  = evp_reg;
    assign evicted_dirty = evd_reg;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcount_reg <= NFRAME_W'(FRAMES))
        else $error("FIFO load queue count exceeds frame count");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !res_valid_reg)
        else $error("Result pending while a transaction is in progress");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (status_reg == STAT_HIT || status_reg == STAT_FAULT)
        |-> (evp_reg == '0) && !evd_reg)
        else $error("Eviction reported without an eviction");

endmodule

// ===== tb/page_translate_replace_unit_test.sv =====
`timescale 1ns / 1ps

module page_translate_replace_unit_test;
    import ptr_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_SPARE  = 2'd3;
    localparam int DRAIN_CYCLES = 600;

    typedef struct packed {
        logic [2:0]         status;
        logic [PHYS_W-1:0]  phys_addr;
        logic [FRAME_W-1:0] frame_used;
        logic [PAGE_W-1:0]  evicted_page;
        logic               evicted_dirty;
    } xlate_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [1:0]          req_type = '0;
    logic [ADDR_W-1:0]   virt_addr = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [2:0]          status;
    logic [PHYS_W-1:0]   phys_addr;
    logic [FRAME_W-1:0]  frame_used;
    logic [PAGE_W-1:0]   evicted_page;
    logic                evicted_dirty;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [6:0]          cfg_data = '0;

    page_translate_replace_unit uut (.*);

    always #1 clk = ~clk;

    // Shadow translation state.
    logic [1:0]         sh_policy;
    logic [6:0]         sh_pages;
    logic [4:0]         sh_frames;
    bit                 pt_valid [PAGES];
    logic [FRAME_W-1:0] pt_frame [PAGES];
    bit                 pt_dirty [PAGES];
    bit                 pt_ref [PAGES];
    longint unsigned    pt_last [PAGES];
    bit                 frame_busy [FRAMES];
    logic [PAGE_W-1:0]  load_fifo [FRAMES];
    int                 fifo_head;
    int                 fifo_count;
    int                 hand;
    longint unsigned    now_tick;

    xlate_t expected_xlate [$];
    xlate_t seen_xlate [$];
    int     error_count = 0;
    bit     idling = 1'b1;
    int     stall_left = 0;

    function automatic int active_pages();
        int p;
        p = int'(sh_pages);
        if (p < 1) p = 1;
        if (p > PAGES) p = PAGES;
        return p;
    endfunction

    function automatic int active_frames();
        int lim;
        int f;
        lim = active_pages();
        f = int'(sh_frames);
        if (lim > FRAMES) lim = FRAMES;
        if (f < 1) f = 1;
        if (f > lim) f = lim;
        return f;
    endfunction

    function automatic bit fifo_mode();
        return sh_policy == POL_FIFO || sh_policy == POL_SPARE;
    endfunction

    function automatic int lowest_mapped(int np);
        for (int i = 0; i < np; i++)
            if (pt_valid[i]) return i;
        return 0;
    endfunction

    function automatic int lowest_free(int nf);
        for (int i = 0; i < nf; i++)
            if (!frame_busy[i]) return i;
        return -1;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < PAGES; i++)
        begin
            pt_valid[i] = 0;
            pt_frame[i] = '0;
            pt_dirty[i] = 0;
            pt_ref[i] = 0;
            pt_last[i] = 0;
        end
        for (int i = 0; i < FRAMES; i++)
            frame_busy[i] = 0;
        fifo_head = 0;
        fifo_count = 0;
        hand = 0;
    endfunction

    function automatic int choose_victim(int np);
        int v;
        int c;
        longint unsigned best;
        if (fifo_mode())
        begin
            if (fifo_count == 0) return lowest_mapped(np);
            v = int'(load_fifo[fifo_head]);
            fifo_head = (fifo_head + 1) % FRAMES;
            fifo_count--;
            return v;
        end
        if (sh_policy == POL_LRU)
        begin
            v = 0;
            best = 64'hFFFF_FFFF_FFFF_FFFF;
            for (int i = 0; i < np; i++)
                if (pt_valid[i] && pt_last[i] < best)
                begin
                    best = pt_last[i];
                    v = i;
                end
            return v;
        end
        if (hand >= np) hand = 0;
        for (int i = 0; i < 2 * np; i++)
        begin
            c = hand;
            hand = (hand + 1) % np;
            if (pt_valid[c])
            begin
                if (!pt_ref[c]) return c;
                pt_ref[c] = 0;
            end
        end
        return lowest_mapped(np);
    endfunction

    function automatic void translate(logic [1:0] kind, logic [ADDR_W-1:0] va);
        xlate_t r;
        int np;
        int nf;
        int pg;
        int ff;
        int v;
        logic [FRAME_W-1:0] fr;
        r = '0;
        np = active_pages();
        nf = active_frames();
        if (kind == REQ_UNUSED) return;
        if (kind == REQ_FLUSH)
        begin
            clear_tables();
            r.status = STAT_FLUSHED;
            expected_xlate.push_back(r);
            return;
        end
        now_tick++;
        if (int'(va[ADDR_W-1:OFFSET_BITS]) >= np)
        begin
            r.status = STAT_INVALID;
            expected_xlate.push_back(r);
            return;
        end
        pg = int'(va[ADDR_W-1:OFFSET_BITS]);
        if (pt_valid[pg])
        begin
            pt_ref[pg] = 1;
            pt_last[pg] = now_tick;
            fr = pt_frame[pg];
            r.status = STAT_HIT;
        end
        else
        begin
            ff = lowest_free(nf);
            r.status = STAT_FAULT;
            if (ff < 0)
            begin
                v = choose_victim(np);
                if (pt_valid[v])
                begin
                    r.evicted_page = PAGE_W'(v);
                    r.evicted_dirty = pt_dirty[v];
                    frame_busy[pt_frame[v]] = 0;
                    pt_valid[v] = 0;
                    pt_frame[v] = '0;
                    pt_dirty[v] = 0;
                    pt_ref[v] = 0;
                    pt_last[v] = 0;
                    r.status = STAT_EVICT;
                end
                ff = lowest_free(nf);
                if (ff < 0)
                begin
                    r.status = STAT_INVALID;
                    expected_xlate.push_back(r);
                    return;
                end
            end
            fr = FRAME_W'(ff);
            frame_busy[ff] = 1;
            pt_valid[pg] = 1;
            pt_frame[pg] = fr;
            pt_dirty[pg] = 0;
            pt_ref[pg] = 1;
            pt_last[pg] = now_tick;
            if (fifo_mode() && fifo_count < FRAMES)
            begin
                load_fifo[(fifo_head + fifo_count) % FRAMES] = PAGE_W'(pg);
                fifo_count++;
            end
        end
        if (kind == REQ_WRITE) pt_dirty[pg] = 1;
        r.phys_addr = {fr, va[OFFSET_BITS-1:0]};
        r.frame_used = fr;
        expected_xlate.push_back(r);
    endfunction

    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            seen_xlate.push_back({status, phys_addr, frame_used, evicted_page, evicted_dirty});
    end

    always @(negedge clk)
    begin
        xlate_t e;
        xlate_t g;
        while (seen_xlate.size() > 0)
        begin
            g = seen_xlate.pop_front();
            if (expected_xlate.size() == 0)
            begin
                $error("unexpected transaction: status %0d phys_addr %h", g.status, g.phys_addr);
                error_count++;
            end
            else
            begin
                e = expected_xlate.pop_front();
                if (g.status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, g.status);
                    error_count++;
                end
                if (g.phys_addr !== e.phys_addr)
                begin
                    $error("phys_addr expected %h actual %h", e.phys_addr, g.phys_addr);
                    error_count++;
                end
                if (g.frame_used !== e.frame_used)
                begin
                    $error("frame_used expected %0d actual %0d", e.frame_used, g.frame_used);
                    error_count++;
                end
                if (g.evicted_page !== e.evicted_page)
                begin
                    $error("evicted_page expected %0d actual %0d",
                           e.evicted_page, g.evicted_page);
                    error_count++;
                end
                if (g.evicted_dirty !== e.evicted_dirty)
                begin
                    $error("evicted_dirty expected %0d actual %0d",
                           e.evicted_dirty, g.evicted_dirty);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall = 1'b1;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            res_stall = 1'b1;
        end
        else
        begin
            res_stall = 1'b0;
        end
    end

    task automatic send_request(logic [1:0] kind, logic [ADDR_W-1:0] va);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_valid = 1'b1;
        req_type = kind;
        virt_addr = va;
        do @(posedge clk); while (req_stall);
        translate(kind, va);
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_xlate.size() > 0 || seen_xlate.size() > 0) @(negedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [6:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_POLICY: sh_policy = value[1:0];
            CFG_PAGES:  sh_pages = value;
            CFG_FRAMES: sh_frames = value[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup(logic [1:0] pol, logic [6:0] pages, logic [4:0] frames);
        write_register(CFG_POLICY, {5'd0, pol});
        write_register(CFG_PAGES, pages);
        write_register(CFG_FRAMES, {2'd0, frames});
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(int pg);
        return {pg[ADDR_W-OFFSET_BITS-1:0], OFFSET_BITS'($urandom)};
    endfunction

    task automatic test_directed();
        setup(POL_FIFO, 7'd4, 5'd2);
        send_request(REQ_READ, 32'h0000_0000);
        send_request(REQ_WRITE, 32'h0000_1FFF);
        send_request(REQ_READ, 32'h0000_0ABC);
        send_request(REQ_WRITE, 32'h0000_2123);
        send_request(REQ_READ, 32'h0000_3FFF);
        send_request(REQ_READ, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 32'h0000_4000);
        send_request(REQ_UNUSED, 32'h0000_1000);
        send_request(REQ_FLUSH, 32'hFFFF_FFFF);
        send_request(REQ_READ, 32'h0000_2555);
        setup(POL_SPARE, 7'd0, 5'd0);
        send_request(REQ_WRITE, 32'h0000_0FFF);
        send_request(REQ_READ, 32'h0000_1000);
        send_request(REQ_READ, 32'h0000_0001);
        setup(POL_LRU, 7'd127, 5'd31);
        for (int i = 0; i < 4; i++) send_request(REQ_WRITE, page_addr(60 + i));
        send_request(REQ_READ, 32'h0003_F000);
        send_request(REQ_READ, 32'h0004_0000);
        send_request(REQ_FLUSH, 32'h0);
    endtask

    task automatic test_policy(logic [1:0] pol, logic [6:0] pages, logic [4:0] frames,
                               int count);
        int np;
        int sel;
        int span;
        setup(pol, pages, frames);
        np = active_pages();
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            span = (np > active_frames() + 3) ? active_frames() + 3 : np;
            if (sel < 2)
                send_request(REQ_FLUSH, $urandom);
            else if (sel < 4)
                send_request(REQ_UNUSED, $urandom);
            else if (sel < 9)
                send_request(2'($urandom_range(0, 1)), $urandom);
            else if (sel < 60)
                send_request(2'($urandom_range(0, 1)),
                             page_addr($urandom_range(0, span - 1)));
            else
                send_request(2'($urandom_range(0, 1)), page_addr($urandom_range(0, np - 1)));
            if (i == count / 2) wait_drained();
        end
    endtask

    initial
    begin
        sh_policy = POL_FIFO;
        sh_pages = 7'd64;
        sh_frames = 5'd16;
        now_tick = 0;
        clear_tables();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_policy(POL_FIFO, 7'd64, 5'd16, 130);
        test_policy(POL_LRU, 7'd64, 5'd16, 130);
        test_policy(POL_CLOCK, 7'd64, 5'd16, 130);
        test_policy(POL_FIFO, 7'd8, 5'd3, 110);
        test_policy(POL_LRU, 7'd5, 5'd1, 100);
        test_policy(POL_CLOCK, 7'd12, 5'd4, 110);
        test_policy(POL_SPARE, 7'd20, 5'd31, 100);
        test_policy(POL_CLOCK, 7'd1, 5'd16, 40);
        idling = 1'b0;
        test_policy(POL_LRU, 7'd32, 5'd8, 100);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
            $display("page_translate_replace_unit_test: clean");
        else
            $display("page_translate_replace_unit_test: errors");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("page_translate_replace_unit_test: errors");
        $finish;
    end

endmodule
